/* design/imadec_pkg.sv */
// ---------------------------------------------------------------------------
// imadec_pkg
// Types, constants and table functions for the IMA ADPCM channel decoder.
// ---------------------------------------------------------------------------
package imadec_pkg;

  localparam int PosW    = 26;
  localparam int IdxW    = 7;
  localparam int StepW   = 15;
  localparam int SampleW = 16;

  localparam logic [IdxW-1:0] IdxMax = 7'd88;

  localparam logic signed [18:0] ValMax = 19'sd32767;
  localparam logic signed [18:0] ValMin = -19'sd32767;

  localparam logic OpStart   = 1'b0;
  localparam logic OpAdvance = 1'b1;

  localparam logic [1:0] CfgRepeatMode = 2'd0;
  localparam logic [1:0] CfgLoopStart  = 2'd1;
  localparam logic [1:0] CfgDataLength = 2'd2;

  typedef logic [PosW-1:0]           pos_t;
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [IdxW-1:0]           idx_t;

  // index adjustment per nibble magnitude
  function automatic logic signed [7:0] idx_delta(input logic [2:0] mag);
    logic signed [7:0] d;
    case (mag)
      3'd4:    d = 8'sd2;
      3'd5:    d = 8'sd4;
      3'd6:    d = 8'sd6;
      3'd7:    d = 8'sd8;
      default: d = -8'sd1;
    endcase
    return d;
  endfunction

  // standard 89-entry step size table
  function automatic logic [StepW-1:0] step_size(input idx_t idx);
    logic [StepW-1:0] s;
    case (idx)
      7'd0:  s = 15'h0007; 7'd1:  s = 15'h0008; 7'd2:  s = 15'h0009; 7'd3:  s = 15'h000A;
      7'd4:  s = 15'h000B; 7'd5:  s = 15'h000C; 7'd6:  s = 15'h000D; 7'd7:  s = 15'h000E;
      7'd8:  s = 15'h0010; 7'd9:  s = 15'h0011; 7'd10: s = 15'h0013; 7'd11: s = 15'h0015;
      7'd12: s = 15'h0017; 7'd13: s = 15'h0019; 7'd14: s = 15'h001C; 7'd15: s = 15'h001F;
      7'd16: s = 15'h0022; 7'd17: s = 15'h0025; 7'd18: s = 15'h0029; 7'd19: s = 15'h002D;
      7'd20: s = 15'h0032; 7'd21: s = 15'h0037; 7'd22: s = 15'h003C; 7'd23: s = 15'h0042;
      7'd24: s = 15'h0049; 7'd25: s = 15'h0050; 7'd26: s = 15'h0058; 7'd27: s = 15'h0061;
      7'd28: s = 15'h006B; 7'd29: s = 15'h0076; 7'd30: s = 15'h0082; 7'd31: s = 15'h008F;
      7'd32: s = 15'h009D; 7'd33: s = 15'h00AD; 7'd34: s = 15'h00BE; 7'd35: s = 15'h00D1;
      7'd36: s = 15'h00E6; 7'd37: s = 15'h00FD; 7'd38: s = 15'h0117; 7'd39: s = 15'h0133;
      7'd40: s = 15'h0151; 7'd41: s = 15'h0173; 7'd42: s = 15'h0198; 7'd43: s = 15'h01C1;
      7'd44: s = 15'h01EE; 7'd45: s = 15'h0220; 7'd46: s = 15'h0256; 7'd47: s = 15'h0292;
      7'd48: s = 15'h02D4; 7'd49: s = 15'h031C; 7'd50: s = 15'h036C; 7'd51: s = 15'h03C3;
      7'd52: s = 15'h0424; 7'd53: s = 15'h048E; 7'd54: s = 15'h0502; 7'd55: s = 15'h0583;
      7'd56: s = 15'h0610; 7'd57: s = 15'h06AB; 7'd58: s = 15'h0756; 7'd59: s = 15'h0812;
      7'd60: s = 15'h08E0; 7'd61: s = 15'h09C3; 7'd62: s = 15'h0ABD; 7'd63: s = 15'h0BD0;
      7'd64: s = 15'h0CFF; 7'd65: s = 15'h0E4C; 7'd66: s = 15'h0FBA; 7'd67: s = 15'h114C;
      7'd68: s = 15'h1307; 7'd69: s = 15'h14EE; 7'd70: s = 15'h1706; 7'd71: s = 15'h1954;
      7'd72: s = 15'h1BDC; 7'd73: s = 15'h1EA5; 7'd74: s = 15'h21B6; 7'd75: s = 15'h2515;
      7'd76: s = 15'h28CA; 7'd77: s = 15'h2CDF; 7'd78: s = 15'h315B; 7'd79: s = 15'h364B;
      7'd80: s = 15'h3BB9; 7'd81: s = 15'h41B2; 7'd82: s = 15'h4844; 7'd83: s = 15'h4F7E;
      7'd84: s = 15'h5771; 7'd85: s = 15'h602F; 7'd86: s = 15'h69CE; 7'd87: s = 15'h7462;
      default: s = 15'h7FFF;
    endcase
    return s;
  endfunction

endpackage

/* design/ima_adpcm_channel_decoder.sv */
// ---------------------------------------------------------------------------
// ima_adpcm_channel_decoder
// One-channel 4-bit IMA ADPCM decoder, at most one sample step per input beat.
// ---------------------------------------------------------------------------
// Each input beat is a start (tuser 0) or a one-sample advance (tuser 1) and
// yields exactly one output beat with the current sample, whether the stream
// word was consumed, and whether the channel is still playing. Feed the 32-bit
// header at nibble position 0, then data bytes in the low eight bits of
// in_tdata; check data_taken to know when to move on to the next word. The
// block takes one beat per clock while out_tready is high: a beat is held in
// the input register, the step (step-table lookup, add, clamps) is computed
// combinationally from it and the channel state, and the result lands in the
// output register. Write the configuration registers only while no beat is
// in flight.
module ima_adpcm_channel_decoder
  import imadec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // stream_word
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // sample_out[15:0], data_taken, running, zero pad
);

  logic [1:0]  repeat_mode_r;
  logic [17:0] loop_start_r;
  logic [23:0] data_length_r;

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [31:0] s1_word_r;

  logic        out_valid_r;
  logic [23:0] out_data_r;

  pos_t        pos_r, pos_nxt;
  sample_t     pred_r, pred_nxt;
  idx_t        idx_r, idx_nxt;
  sample_t     loop_val_r, loop_val_nxt;
  idx_t        loop_idx_r, loop_idx_nxt;
  logic [7:0]  code_r, code_nxt;
  sample_t     held_r, held_nxt;
  logic        active_r, active_nxt;
  logic        taken;

  logic        advance;
  logic        fire;

  // decode datapath
  logic [3:0]          nib;
  logic [StepW-1:0]    step;
  logic [16:0]         diff;
  logic signed [18:0]  sum;
  sample_t             dec_val;
  logic signed [7:0]   idx_sum;
  idx_t                dec_idx;
  pos_t                pos_inc;
  logic [24:0]         total;
  logic                at_end;
  logic [6:0]          hdr_idx;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_mode_r <= '0;
      loop_start_r  <= '0;
      data_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRepeatMode: repeat_mode_r <= cfg_data[1:0];
        CfgLoopStart:  loop_start_r  <= cfg_data[17:0];
        CfgDataLength: data_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_word_r <= in_tdata;
    end
  end

  assign pos_inc = pos_r + 1'b1;
  assign total   = {7'd0, loop_start_r} + {1'b0, data_length_r};
  assign at_end  = pos_inc[PosW-1:1] >= total;
  assign nib     = pos_inc[0] ? code_r[7:4] : s1_word_r[3:0];
  assign hdr_idx = s1_word_r[22:16];

  always_comb begin
    step = step_size(idx_r);
    diff = {5'd0, step[StepW-1:3]};
    if (nib[0]) diff = diff + {4'd0, step[StepW-1:2]};
    if (nib[1]) diff = diff + {3'd0, step[StepW-1:1]};
    if (nib[2]) diff = diff + {2'd0, step};
    if (nib[3]) sum = 19'(signed'(pred_r)) - $signed({2'b00, diff});
    else        sum = 19'(signed'(pred_r)) + $signed({2'b00, diff});
    if (sum > ValMax)      dec_val = sample_t'(ValMax);
    else if (sum < ValMin) dec_val = sample_t'(ValMin);
    else                   dec_val = sample_t'(sum);
    idx_sum = $signed({1'b0, idx_r}) + idx_delta(nib[2:0]);
    if (idx_sum < 0)                          dec_idx = '0;
    else if (idx_sum > $signed({1'b0, IdxMax})) dec_idx = IdxMax;
    else                                      dec_idx = idx_t'(idx_sum);
  end

  always_comb begin
    pos_nxt      = pos_r;
    pred_nxt     = pred_r;
    idx_nxt      = idx_r;
    loop_val_nxt = loop_val_r;
    loop_idx_nxt = loop_idx_r;
    code_nxt     = code_r;
    held_nxt     = held_r;
    active_nxt   = active_r;
    taken        = 1'b0;
    if (s1_op_r == OpStart) begin
      pos_nxt    = pos_t'(-3);
      held_nxt   = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      pos_nxt = pos_inc;
      if (pos_inc[PosW-1] || pos_inc < pos_t'(8)) begin
        if (pos_inc == '0) begin
          pred_nxt     = sample_t'(s1_word_r[15:0]);
          idx_nxt      = (hdr_idx > IdxMax) ? IdxMax : hdr_idx;
          loop_val_nxt = pred_nxt;
          loop_idx_nxt = idx_nxt;
          taken        = 1'b1;
        end
      end else begin
        held_nxt = pred_r;
        if (at_end) begin
          if (repeat_mode_r[0]) begin
            pos_nxt  = pos_t'({loop_start_r, 1'b0});
            pred_nxt = loop_val_r;
            idx_nxt  = loop_idx_r;
            code_nxt = s1_word_r[7:0];
            held_nxt = loop_val_r;
            taken    = 1'b1;
          end else if (repeat_mode_r[1]) begin
            held_nxt   = '0;
            active_nxt = 1'b0;
          end
        end else begin
          if (!pos_inc[0]) begin
            code_nxt = s1_word_r[7:0];
            taken    = 1'b1;
          end else begin
            code_nxt = {4'd0, code_r[7:4]};
          end
          pred_nxt = dec_val;
          idx_nxt  = dec_idx;
          held_nxt = dec_val;
          if (pos_inc == pos_t'({loop_start_r, 1'b0})) begin
            loop_val_nxt = dec_val;
            loop_idx_nxt = dec_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pred_r     <= '0;
      idx_r      <= '0;
      loop_val_r <= '0;
      loop_idx_r <= '0;
      code_r     <= '0;
      held_r     <= '0;
      active_r   <= 1'b0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      pred_r     <= pred_nxt;
      idx_r      <= idx_nxt;
      loop_val_r <= loop_val_nxt;
      loop_idx_r <= loop_idx_nxt;
      code_r     <= code_nxt;
      held_r     <= held_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {6'd0, active_nxt, taken, held_nxt};
    end
  end

endmodule

/* tb/ima_adpcm_channel_decoder_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ima_adpcm_channel_decoder_checker
// Watches the configuration port and both stream channels of the decoder.
// Each accepted input beat is run through a local model of the channel state
// (header load, nibble decode with step table and clamps, loop capture and
// restore, one-shot stop, hold). The expected output beat is queued and each
// accepted output beat is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module ima_adpcm_channel_decoder_checker
  import imadec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // stream_word
  input  logic        in_tuser,   // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // sample_out[15:0], data_taken, running, zero pad
  output int          mismatches,
  output int          in_flight
);

  typedef struct packed {
    logic              running;
    logic              taken;
    logic signed [15:0] sample;
  } sample_beat_t;

  localparam logic [89*16-1:0] StepTable = {
    16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
    16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
    16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
    16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
    16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
    16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
    16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
    16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
    16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
    16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
    16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
    16'h7FFF
  };

  logic [1:0]  repeat_mode;
  logic [17:0] loop_start;
  logic [23:0] data_len;

  pos_t        nib_pos;
  int          cur_value;
  int          cur_index;
  int          saved_value;
  int          saved_index;
  logic [7:0]  code_byte;
  sample_t     held;
  logic        playing;

  sample_beat_t expected_q[$];

  task automatic decode_code(input logic [3:0] code);
    int step;
    int diff;
    int mag;
    step = int'(StepTable[(88 - cur_index)*16 +: 16]);
    diff = step >> 3;
    if (code[0]) diff += step >> 2;
    if (code[1]) diff += step >> 1;
    if (code[2]) diff += step;
    if (code[3]) begin
      cur_value -= diff;
      if (cur_value < int'(ValMin)) cur_value = int'(ValMin);
    end else begin
      cur_value += diff;
      if (cur_value > int'(ValMax)) cur_value = int'(ValMax);
    end
    mag = int'(code[2:0]);
    if (mag < 4) cur_index -= 1;
    else cur_index += 2*(mag - 3);
    if (cur_index < 0) cur_index = 0;
    if (cur_index > int'(IdxMax)) cur_index = int'(IdxMax);
  endtask

  task automatic predict_sample(input logic op, input logic [31:0] word,
                                output sample_beat_t r);
    logic [31:0] total;
    logic        ended;
    r.taken = 1'b0;
    ended = 1'b0;
    if (op == OpStart) begin
      nib_pos = 26'h3FF_FFFD;  // minus three
      held = '0;
      playing = 1'b1;
    end else if (playing) begin
      nib_pos = nib_pos + 1'b1;
      if (nib_pos[PosW-1] || nib_pos < 8) begin
        if (nib_pos == '0) begin
          cur_value = int'($signed(word[15:0]));
          cur_index = int'(word[22:16]);
          if (cur_index > int'(IdxMax)) cur_index = int'(IdxMax);
          saved_value = cur_value;
          saved_index = cur_index;
          r.taken = 1'b1;
        end
      end else begin
        total = 32'(loop_start) + 32'(data_len);
        if ({7'd0, nib_pos[PosW-1:1]} >= total) begin
          if (repeat_mode[0]) begin
            nib_pos = {7'd0, loop_start, 1'b0};
            cur_value = saved_value;
            cur_index = saved_index;
            code_byte = word[7:0];
            r.taken = 1'b1;
          end else if (repeat_mode[1]) begin
            held = '0;
            playing = 1'b0;
            ended = 1'b1;
          end
        end else begin
          if (!nib_pos[0]) begin
            code_byte = word[7:0];
            r.taken = 1'b1;
          end else begin
            code_byte = code_byte >> 4;
          end
          decode_code(code_byte[3:0]);
          if (nib_pos == {7'd0, loop_start, 1'b0}) begin
            saved_value = cur_value;
            saved_index = cur_index;
          end
        end
        if (!ended) held = cur_value[15:0];
      end
    end
    r.sample = held;
    r.running = playing;
  endtask

  always @(posedge clk) begin : track
    sample_beat_t want;
    sample_beat_t got;
    if (!rst_n) begin
      repeat_mode = '0;
      loop_start = '0;
      data_len = '0;
      nib_pos = '0;
      cur_value = 0;
      cur_index = 0;
      saved_value = 0;
      saved_index = 0;
      code_byte = '0;
      held = '0;
      playing = 1'b0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata[15:0];
        got.taken = out_tdata[16];
        got.running = out_tdata[17];
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, actual sample %0d taken %0b running %0b",
                   $time, got.sample, got.taken, got.running);
        end else begin
          want = expected_q.pop_front();
          if (got.sample !== want.sample || got.taken !== want.taken ||
              got.running !== want.running) begin
            mismatches++;
            $display({"%0t: expected sample %0d taken %0b running %0b, ",
                      "actual sample %0d taken %0b running %0b"},
                     $time, want.sample, want.taken, want.running,
                     got.sample, got.taken, got.running);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CfgRepeatMode: repeat_mode = cfg_data[1:0];
          CfgLoopStart:  loop_start = cfg_data[17:0];
          CfgDataLength: data_len = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_sample(in_tuser, in_tdata, want);
        expected_q.push_back(want);
      end
    end
    in_flight = expected_q.size();
  end

endmodule

/* tb/ima_adpcm_channel_decoder_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ima_adpcm_channel_decoder_tb
// Drives the decoder with start and advance beats in bursts against a stalling
// receiver. A short directed run covers header clamps, value clamps, loop
// restore and restart; then phases of random sessions run under several
// repeat modes and loop/length settings, extremes included. The checker
// predicts and compares every output beat.
// ---------------------------------------------------------------------------
module ima_adpcm_channel_decoder_tb;
  import imadec_pkg::*;

  localparam logic [1:0] ModeHold     = 2'd0;
  localparam logic [1:0] ModeLoop     = 2'd1;
  localparam logic [1:0] ModeOneShot  = 2'd2;
  localparam logic [1:0] ModeLoopBoth = 2'd3;

  localparam int DirectedBeats = 24;
  localparam int RandomBeats   = 400;
  localparam int PhaseBeats    = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // stream_word
  logic        in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // sample_out[15:0], data_taken, running, zero pad

  int mismatches;
  int in_flight;
  int burst_left;
  int beats_sent;
  bit stall_req;

  always #4 clk = ~clk;

  ima_adpcm_channel_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ima_adpcm_channel_decoder_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  task automatic send_beat(input logic op, input logic [31:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [17:0] loop_at,
                           input logic [23:0] length);
    drain();
    write_reg(CfgRepeatMode, {22'd0, mode});
    write_reg(CfgLoopStart, {6'd0, loop_at});
    write_reg(CfgDataLength, length);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // start, then a run of advances; the third advance lands on the header
  task automatic play_session(input int advances);
    logic [31:0] word;
    send_beat(OpStart, $urandom);
    for (int i = 1; i <= advances; i++) begin
      word = $urandom;
      if (i == 3 && $urandom_range(0, 3) != 0) word[22:16] = 7'($urandom_range(0, 88));
      send_beat(OpAdvance, word);
    end
  endtask

  // receiver: random stall segments, plus one long hold-off on request
  initial begin : sink
    int seg_left;
    int stall_pct;
    int hold_left;
    bit hold_served;
    out_tready = 1'b0;
    seg_left = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  mode;
    logic [17:0] loop_at;
    logic [23:0] length;
    int          phase;
    int          phase_base;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OpStart;
    burst_left = 0;
    beats_sent = 0;
    stall_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle channel, clamped header, value clamps, loop, restart
    configure(ModeLoop, 18'd4, 24'd3);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpStart, 32'hFFFF_FFFF);
    send_beat(OpAdvance, 32'hFFFF_FFFF);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpAdvance, 32'h007F_7FFF);
    for (int i = 0; i < 7; i++) send_beat(OpAdvance, i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
    send_beat(OpAdvance, 32'h0000_0077);
    send_beat(OpAdvance, 32'hFFFF_FF00);
    send_beat(OpAdvance, 32'h0000_008F);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpAdvance, 32'hFFFF_FF00);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpAdvance, 32'h0000_0008);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpStart, 32'h0000_0000);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpAdvance, 32'h0000_0000);
    send_beat(OpAdvance, 32'h0000_8000);

    for (phase = 0; beats_sent < DirectedBeats + RandomBeats; phase++) begin
      case (phase)
        0: begin mode = ModeOneShot;  loop_at = 18'd5;   length = 24'd4; end
        1: begin mode = ModeHold;     loop_at = 18'd4;   length = 24'd5; end
        2: begin mode = ModeLoopBoth; loop_at = 18'd0;   length = 24'd10; end
        3: begin mode = ModeOneShot;  loop_at = '1;      length = '1; end
        4: begin mode = ModeLoop;     loop_at = 18'd3;   length = 24'd0; end
        5: begin mode = ModeHold;     loop_at = 18'd0;   length = 24'd0; end
        default: begin
          mode = 2'($urandom_range(0, 3));
          loop_at = ($urandom_range(0, 9) < 7) ? 18'($urandom_range(0, 8)) : 18'($urandom);
          length = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(0, 8)) : 24'($urandom);
        end
      endcase
      configure(mode, loop_at, length);
      if (phase == 2) stall_req = 1'b1;
      phase_base = beats_sent;
      while (beats_sent - phase_base < PhaseBeats) begin
        play_session(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
                                                 : $urandom_range(12, 44));
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
